>>> src/dts_pkg.sv
// dts_pkg: shared constants and word types of the trinucleotide dust scorer
// no dependencies; compiled first
package dts_pkg;

    localparam int MAX_LEN = 4096;
    localparam int NBINS   = 64;
    localparam int BIN_W   = $clog2(NBINS);
    localparam int CNT_W   = 12;
    localparam int SCORE_W = 24;

    localparam int CNT_CAP   = (1 << CNT_W) - 1;
    localparam int CNT_LIMIT = ((MAX_LEN - 2) > CNT_CAP) ? CNT_CAP : (MAX_LEN - 2);

    localparam logic [CNT_W-1:0]   CNT_LIM_V = CNT_W'(CNT_LIMIT);
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // input word: one base per path plus end-of-sequence flag
    typedef struct packed {
        logic [1:0] base_a;
        logic [1:0] base_b;
        logic       last_base;
    } t_in_word;

    typedef struct packed {
        logic [SCORE_W-1:0] dust_score;
    } t_out_word;

    typedef struct packed {
        logic two_paths;
    } t_cfg_word;

    // histogram access of one path, formed at accept
    typedef struct packed {
        logic             take;
        logic [BIN_W-1:0] addr;
    } t_path_req;

    typedef struct packed {
        logic      vld;
        logic      last;
        t_path_req a;
        t_path_req b;
    } t_s1;

endpackage

>>> src/dts_stream_if.sv
// dts_stream_if: valid/ready channel carrying one word of type T
// no dependencies; the word type comes from dts_pkg at instantiation
interface dts_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/dust_trinucleotide_score.sv
// dust_trinucleotide_score: dust low-complexity score over trinucleotides, two paths
// depends on dts_pkg, dts_stream_if and dts_ram
//
//   channel  dir  word            handshake
//   -------  ---  --------------  -----------------------------------------
//   i_cfg    in   two_paths       valid/ready, ready always high
//   i_in     in   base_a, base_b, valid/ready, one base pair per word
//                 last_base
//   o_out    out  dust_score      valid/ready, one word per last_base input
//
// one input word per cycle while i_in.ready is high; a score goes through the
// histogram ram read, then count update and the 3-entry output queue
// each path's histogram is a 64x12 ram read at accept and written back in the
// following cycle; a one-entry forward register covers back-to-back hits
// per-sequence clear is instant: 64 valid bits per path drop on last_base
// i_in.ready drops only while the output queue would have no room, which
// happens only when the sink stalls
// reset is synchronous: clears control state, valid bits, score; two_paths=1
module dust_trinucleotide_score (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dts_stream_if.sink   i_cfg,
    dts_stream_if.sink   i_in,
    dts_stream_if.source o_out
);
    import dts_pkg::*;

    // configuration
    logic r_two_paths;

    // stage 0: base history per path
    logic [3:0] r_recent_a, r_recent_b;
    logic [1:0] r_seen_a, r_seen_b;
    logic       acc;
    t_in_word   in_w;
    t_path_req  req_a, req_b;

    // stage 1: read data back, update
    t_s1                r_s1;
    logic [CNT_W-1:0]   rd_a, rd_b;
    logic [CNT_W-1:0]   m_a, m_b;
    logic               upd_a, upd_b;
    logic [NBINS-1:0]   r_vld_a, r_vld_b;
    logic               r_fw_a_vld, r_fw_b_vld;
    logic [BIN_W-1:0]   r_fw_a_addr, r_fw_b_addr;
    logic [CNT_W-1:0]   r_fw_a_data, r_fw_b_data;
    logic [SCORE_W-1:0] r_score, score_sat;
    logic [SCORE_W+1:0] score_sum;
    logic               clr, push;

    // output queue, entry 0 is the head
    logic [2:0]         r_q_vld, q_vld_sh, n_q_vld;
    logic [SCORE_W-1:0] r_q_data [3];
    logic [SCORE_W-1:0] q_data_sh [3];
    logic [SCORE_W-1:0] n_q_data [3];
    logic               pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_paths <= 1'b1;
        end else if (i_cfg.valid) begin
            r_two_paths <= i_cfg.data.two_paths;
        end
    end

    // accept while the queue can absorb any result still in flight
    assign i_in.ready = !(r_q_vld[2] || (r_q_vld[1] && r_s1.vld && r_s1.last));
    assign acc        = i_in.valid && i_in.ready;
    assign in_w       = i_in.data;

    // oldest base lands in the high bits of the bin index
    always_comb begin
        req_a.take = (r_seen_a == 2'd2);
        req_a.addr = {r_recent_a, in_w.base_a};
        req_b.take = r_two_paths && (r_seen_b == 2'd2);
        req_b.addr = {r_recent_b, in_w.base_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent_a <= '0;
            r_recent_b <= '0;
            r_seen_a   <= '0;
            r_seen_b   <= '0;
        end else if (acc) begin
            if (in_w.last_base) begin
                r_recent_a <= '0;
                r_recent_b <= '0;
                r_seen_a   <= '0;
                r_seen_b   <= '0;
            end else begin
                r_recent_a <= {r_recent_a[1:0], in_w.base_a};
                if (r_seen_a != 2'd2) begin
                    r_seen_a <= r_seen_a + 2'd1;
                end
                // path b moves only while it is being scored
                if (r_two_paths) begin
                    r_recent_b <= {r_recent_b[1:0], in_w.base_b};
                    if (r_seen_b != 2'd2) begin
                        r_seen_b <= r_seen_b + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= acc;
        end
        r_s1.last <= in_w.last_base;
        r_s1.a    <= req_a;
        r_s1.b    <= req_b;
    end

    dts_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (upd_a),
        .i_waddr (r_s1.a.addr),
        .i_wdata (m_a + CNT_W'(1)),
        .i_raddr (req_a.addr),
        .o_rdata (rd_a)
    );

    dts_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (upd_b),
        .i_waddr (r_s1.b.addr),
        .i_wdata (m_b + CNT_W'(1)),
        .i_raddr (req_b.addr),
        .o_rdata (rd_b)
    );

    // previous count: last cycle's write first, then ram if the bin is live
    always_comb begin
        if (r_fw_a_vld && (r_fw_a_addr == r_s1.a.addr)) begin
            m_a = r_fw_a_data;
        end else if (r_vld_a[r_s1.a.addr]) begin
            m_a = rd_a;
        end else begin
            m_a = '0;
        end
        if (r_fw_b_vld && (r_fw_b_addr == r_s1.b.addr)) begin
            m_b = r_fw_b_data;
        end else if (r_vld_b[r_s1.b.addr]) begin
            m_b = rd_b;
        end else begin
            m_b = '0;
        end
    end

    // a saturated bin neither counts nor scores
    assign upd_a = r_s1.vld && r_s1.a.take && (m_a < CNT_LIM_V);
    assign upd_b = r_s1.vld && r_s1.b.take && (m_b < CNT_LIM_V);
    assign clr   = r_s1.vld && r_s1.last;
    assign push  = clr;

    assign score_sum = {2'b00, r_score}
                     + (SCORE_W+2)'(upd_a ? m_a : '0)
                     + (SCORE_W+2)'(upd_b ? m_b : '0);
    assign score_sat = (score_sum > (SCORE_W+2)'(SCORE_MAX)) ? SCORE_MAX
                                                              : score_sum[SCORE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score    <= '0;
            r_vld_a    <= '0;
            r_vld_b    <= '0;
            r_fw_a_vld <= 1'b0;
            r_fw_b_vld <= 1'b0;
        end else begin
            if (r_s1.vld) begin
                r_score <= clr ? '0 : score_sat;
            end
            if (clr) begin
                r_vld_a    <= '0;
                r_vld_b    <= '0;
                r_fw_a_vld <= 1'b0;
                r_fw_b_vld <= 1'b0;
            end else begin
                if (upd_a) begin
                    r_vld_a <= r_vld_a | (NBINS'(1) << r_s1.a.addr);
                end
                if (upd_b) begin
                    r_vld_b <= r_vld_b | (NBINS'(1) << r_s1.b.addr);
                end
                r_fw_a_vld <= upd_a;
                r_fw_b_vld <= upd_b;
            end
        end
        r_fw_a_addr <= r_s1.a.addr;
        r_fw_a_data <= m_a + CNT_W'(1);
        r_fw_b_addr <= r_s1.b.addr;
        r_fw_b_data <= m_b + CNT_W'(1);
    end

    // output queue: shift on pop, then fill the first free entry
    assign pop         = r_q_vld[0] && o_out.ready;
    assign o_out.valid = r_q_vld[0];
    assign o_out.data  = '{dust_score: r_q_data[0]};

    always_comb begin
        if (pop) begin
            q_vld_sh     = {1'b0, r_q_vld[2:1]};
            q_data_sh[0] = r_q_data[1];
            q_data_sh[1] = r_q_data[2];
            q_data_sh[2] = r_q_data[2];
        end else begin
            q_vld_sh  = r_q_vld;
            q_data_sh = r_q_data;
        end
    end

    // entries stay packed from the head, so the first free one takes the push
    always_comb begin
        n_q_vld  = q_vld_sh;
        n_q_data = q_data_sh;
        if (push) begin
            priority if (!q_vld_sh[0]) begin
                n_q_vld[0]  = 1'b1;
                n_q_data[0] = score_sat;
            end else if (!q_vld_sh[1]) begin
                n_q_vld[1]  = 1'b1;
                n_q_data[1] = score_sat;
            end else begin
                n_q_vld[2]  = 1'b1;
                n_q_data[2] = score_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= '0;
        end else begin
            r_q_vld <= n_q_vld;
        end
        r_q_data <= n_q_data;
    end

    // a result never arrives at a full queue that is not draining
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && r_q_vld[2] && !pop))
        else $error("output queue overflow");

    // the score restarts after every emitted result
    a_score_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> (r_score == '0) && (r_vld_a == '0) && (r_vld_b == '0))
        else $error("sequence state not cleared after result");

    // a forwarded path-a count always belongs to a live bin
    a_fw_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fw_a_vld |-> r_vld_a[r_fw_a_addr])
        else $error("forwarded count on a cleared bin");

    // base history never passes two bases
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen_a != 2'd3) && (r_seen_b != 2'd3))
        else $error("base history counter out of range");

endmodule

>>> src/dts_ram.sv
// dts_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dts_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
